[rtl/srssc_pkg.sv]
// package: anomaly codes, register indexes and field widths of the sensor checker
package srssc_pkg;

    // field widths
    localparam int unsigned CH_W    = 3;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SPIKE_W = 31;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_W   = 2;

    // anomaly kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_NONE   = 2'd0;
    localparam t_kind KIND_RANGE  = 2'd1;
    localparam t_kind KIND_SPIKE  = 2'd2;
    localparam t_kind KIND_FROZEN = 2'd3;

    // register indexes
    typedef logic [CFG_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_MIN_VALUE   = 2'd0;
    localparam t_cfg_index REG_MAX_VALUE   = 2'd1;
    localparam t_cfg_index REG_SPIKE_LIMIT = 2'd2;
    localparam t_cfg_index REG_STUCK_LIMIT = 2'd3;

    // repeat counter saturation value
    localparam logic [CNT_W-1:0] REPEAT_MAX = 16'hFFFF;

endpackage

[rtl/sensor_range_spike_stuck_check.sv]
// top level: per-channel range, spike and stuck check of multi-channel sensor samples
//
// Usage: a sample arrives as one channel value per item on the input channel
// (i_in_valid / o_in_ready), ascending channel order, with i_end_of_sample set
// on the last value. Each value is range checked, and once the block is primed
// also spike checked against the channel's previous value and stuck checked
// with a saturating repeat counter. The first anomaly of the sample is held and
// leaves as one result item on the output channel (o_out_valid / i_out_ready)
// for the item that ends the sample; other items give no result.
// Throughput: one item per cycle while the input does not stall (see Stall).
// Items pass the input register; an end-of-sample item then loads the result register.
// The per-channel state is read, tested and written back in the same cycle, so
// consecutive values of one channel need no forwarding.
// Stall: while a result waits, items that do not end a sample keep flowing; an
// end-of-sample item waits in the input register until the result is taken.
// Reset (i_rst_n low, synchronous) and any register write clear all channel
// state, the pending anomaly and the primed flag; reset also clears the
// registers. Write registers only while the block is idle.
module sensor_range_spike_stuck_check #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  srssc_pkg::t_cfg_index               i_cfg_index,
    input  logic [srssc_pkg::VAL_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [srssc_pkg::CH_W-1:0]          i_channel_index,
    input  logic signed [srssc_pkg::VAL_W-1:0]  i_sample_value,
    input  logic                                i_end_of_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output srssc_pkg::t_kind                    o_anomaly_kind,
    output logic [srssc_pkg::CH_W-1:0]          o_anomaly_channel,
    output logic signed [srssc_pkg::VAL_W-1:0]  o_anomaly_value
);
    import srssc_pkg::*;

    // only channels the index field can reach need storage
    localparam int MAX_REACH = 1 << CH_W;
    localparam int DEPTH     = (NUM_CHANNELS < MAX_REACH) ? NUM_CHANNELS : MAX_REACH;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic signed [VAL_W-1:0] r_min_value;
    logic signed [VAL_W-1:0] r_max_value;
    logic [SPIKE_W-1:0]      r_spike_limit;
    logic [CNT_W-1:0]        r_stuck_limit;
    logic                    w_clear;

    // per-channel state and sample state
    logic [VAL_W-1:0]        r_prev [DEPTH];
    logic [CNT_W-1:0]        r_cnt  [DEPTH];
    logic                    r_primed;
    t_kind                   r_pend_kind;
    logic [CH_W-1:0]         r_pend_ch;
    logic signed [VAL_W-1:0] r_pend_val;

    // input register
    logic                    r_in_valid;
    logic [CH_W-1:0]         r_in_ch;
    logic signed [VAL_W-1:0] r_in_val;
    logic                    r_in_eos;

    // stage signals
    logic                    w_stall;
    logic                    w_fire;
    logic                    w_ch_ok;
    logic [IDX_W-1:0]        w_idx;
    logic signed [VAL_W-1:0] w_prev;
    logic [CNT_W-1:0]        w_cnt;
    logic signed [VAL_W:0]   w_diff;
    logic [VAL_W:0]          w_mag;
    logic                    w_equal;
    logic                    w_range_bad;
    logic                    w_spike_bad;
    logic                    w_frozen_bad;
    t_kind                   w_item_kind;
    logic [CNT_W-1:0]        n_cnt;
    t_kind                   n_kind;
    logic [CH_W-1:0]         n_ch;
    logic signed [VAL_W-1:0] n_val;

    // configuration writes; every register index clears the state
    always_comb begin
        w_clear = 1'b0;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MIN_VALUE, REG_MAX_VALUE, REG_SPIKE_LIMIT, REG_STUCK_LIMIT: w_clear = 1'b1;
                default: w_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value   <= '0;
            r_max_value   <= '0;
            r_spike_limit <= '0;
            r_stuck_limit <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MIN_VALUE:   r_min_value   <= i_cfg_data;
                REG_MAX_VALUE:   r_max_value   <= i_cfg_data;
                REG_SPIKE_LIMIT: r_spike_limit <= i_cfg_data[SPIKE_W-1:0];
                REG_STUCK_LIMIT: r_stuck_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control: only an end-of-sample item needs the result register
    assign w_stall    = r_in_valid && r_in_eos && o_out_valid && !i_out_ready;
    assign w_fire     = r_in_valid && !w_stall;
    assign o_in_ready = !w_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_ch  <= i_channel_index;
            r_in_val <= i_sample_value;
            r_in_eos <= i_end_of_sample;
        end
    end

    // channel lookup
    assign w_ch_ok = (int'(r_in_ch) < NUM_CHANNELS);
    assign w_idx   = (DEPTH > 1) ? r_in_ch[IDX_W-1:0] : '0;
    assign w_prev  = w_ch_ok ? r_prev[w_idx] : '0;
    assign w_cnt   = w_ch_ok ? r_cnt[w_idx]  : '0;

    // range, spike and stuck tests
    always_comb begin
        w_range_bad = (r_min_value != r_max_value)
                   && ((r_in_val < r_min_value) || (r_in_val > r_max_value));
        w_diff      = {r_in_val[VAL_W-1], r_in_val} - {w_prev[VAL_W-1], w_prev};
        w_mag       = w_diff[VAL_W] ? -w_diff : w_diff;
        w_spike_bad = r_primed && (r_spike_limit != '0)
                   && (w_mag > {2'b00, r_spike_limit});
        w_equal     = (r_in_val == w_prev);
        if (!r_primed) begin
            n_cnt = w_cnt;
        end else if (w_equal) begin
            n_cnt = (w_cnt == REPEAT_MAX) ? w_cnt : w_cnt + 1'b1;
        end else begin
            n_cnt = '0;
        end
        w_frozen_bad = r_primed && (r_stuck_limit != '0) && (n_cnt >= r_stuck_limit);

        if (!w_ch_ok) begin
            w_item_kind = KIND_NONE;
        end else if (w_range_bad) begin
            w_item_kind = KIND_RANGE;
        end else if (w_spike_bad) begin
            w_item_kind = KIND_SPIKE;
        end else if (w_frozen_bad) begin
            w_item_kind = KIND_FROZEN;
        end else begin
            w_item_kind = KIND_NONE;
        end

        // first anomaly of the sample wins
        if (r_pend_kind != KIND_NONE || w_item_kind == KIND_NONE) begin
            n_kind = r_pend_kind;
            n_ch   = r_pend_ch;
            n_val  = r_pend_val;
        end else begin
            n_kind = w_item_kind;
            n_ch   = r_in_ch;
            n_val  = r_in_val;
        end
    end

    // per-channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_prev[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (w_fire && w_ch_ok) begin
            r_prev[w_idx] <= r_in_val;
            r_cnt[w_idx]  <= n_cnt;
        end
    end

    // pending anomaly and primed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_primed    <= 1'b0;
            r_pend_kind <= KIND_NONE;
            r_pend_ch   <= '0;
            r_pend_val  <= '0;
        end else if (w_fire) begin
            if (r_in_eos) begin
                r_primed    <= 1'b1;
                r_pend_kind <= KIND_NONE;
                r_pend_ch   <= '0;
                r_pend_val  <= '0;
            end else begin
                r_pend_kind <= n_kind;
                r_pend_ch   <= n_ch;
                r_pend_val  <= n_val;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_fire && r_in_eos) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_eos) begin
            o_anomaly_kind    <= n_kind;
            o_anomaly_channel <= n_ch;
            o_anomaly_value   <= n_val;
        end
    end

    // a clean sample reports zero channel and value
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_anomaly_kind == KIND_NONE)
            |-> (o_anomaly_channel == '0 && o_anomaly_value == '0))
        else $error("clean result carries channel or value");

    // a register write leaves the block unprimed with nothing pending
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (!r_primed && r_pend_kind == KIND_NONE))
        else $error("register write did not clear state");

    // an end-of-sample item that leaves the stage yields a result
    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_eos) |=> o_out_valid)
        else $error("end of sample gave no result");

    // input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_eos && o_out_valid))
        else $error("input stalled without a waiting result");

    // the pending anomaly is empty right after a result is produced
    a_pend_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_eos) |=> (r_pend_kind == KIND_NONE && r_primed))
        else $error("pending anomaly not cleared after result");

endmodule
